/* hw/rtl/ccfp_pkg.sv */
// ----------------------------------------------------------------------------
// ccfp_pkg
// Shared constants, codes and the CRC-32 byte step for the frame parser.
// ----------------------------------------------------------------------------
package ccfp_pkg;

   localparam int MAX_PAYLOAD_DEFAULT = 512;

   localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

   // register reset values
   localparam logic [7:0]  SYNC_FIRST_RESET   = 8'hAA;
   localparam logic [7:0]  SYNC_SECOND_RESET  = 8'h55;
   localparam logic [15:0] NAV_FRAME_ID_RESET = 16'h0166;
   localparam logic [31:0] CRC_SEED_RESET     = 32'h0000_0001;

   // register indexes
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_SYNC_FIRST   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SYNC_SECOND  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_NAV_FRAME_ID = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CRC_SEED     = 2'd3;

   // frame status codes
   localparam logic [1:0] STATUS_NAV_OK   = 2'd0;
   localparam logic [1:0] STATUS_OTHER_ID = 2'd1;
   localparam logic [1:0] STATUS_CRC_BAD  = 2'd2;

   // captured words: word 0 is time of week, 1..6 start at offset 50
   localparam int NUM_WORDS         = 7;
   localparam int WORD_IDX_W        = 3;
   localparam int FIRST_WORD_OFFSET = 50;
   localparam int LAST_WORD_END     = FIRST_WORD_OFFSET + 4 * (NUM_WORDS - 1);

   typedef logic [31:0] word_type;

   // reflected CRC-32, one byte
   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

/* hw/rtl/ccfp_req_if.sv */
// ----------------------------------------------------------------------------
// ccfp_req_if
// Request channel: one received stream byte per request.
// ----------------------------------------------------------------------------
interface ccfp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

/* hw/rtl/ccfp_rsp_if.sv */
// ----------------------------------------------------------------------------
// ccfp_rsp_if
// Response channel: one frame verdict per finished frame.
// ----------------------------------------------------------------------------
interface ccfp_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  frame_status;
   logic [15:0] pkt_id;
   logic [8:0]  frame_length;
   logic [31:0] time_delta_ms;
   logic [31:0] accel_x_bits;
   logic [31:0] accel_y_bits;
   logic [31:0] accel_z_bits;
   logic [31:0] gyro_x_bits;
   logic [31:0] gyro_y_bits;
   logic [31:0] gyro_z_bits;

   modport source (
      output valid, input ready,
      output frame_status, output pkt_id, output frame_length, output time_delta_ms,
      output accel_x_bits, output accel_y_bits, output accel_z_bits,
      output gyro_x_bits, output gyro_y_bits, output gyro_z_bits
   );
   modport sink (
      input valid, output ready,
      input frame_status, input pkt_id, input frame_length, input time_delta_ms,
      input accel_x_bits, input accel_y_bits, input accel_z_bits,
      input gyro_x_bits, input gyro_y_bits, input gyro_z_bits
   );
endinterface

/* hw/rtl/crc32_checked_frame_parser.sv */
// ----------------------------------------------------------------------------
// crc32_checked_frame_parser
// Sync/length framed packet parser with CRC-32 check and nav field capture.
// ----------------------------------------------------------------------------
// Usage:
//   req_bus carries one stream byte per request (valid/ready). The parser
//   hunts for the two sync bytes, reads id, length, payload and a 4-byte
//   little-endian check word, and on the last check byte issues one
//   response on rsp_bus: good nav frame, other id, or CRC mismatch.
//   csr_* writes the sync bytes, nav id and CRC seed; write only when idle.
// Pipeline / throughput:
//   A request lands in an input register, then one CRC byte step plus the
//   parse-state update writes the state and the response register. One
//   request per cycle is taken unless a waiting response holds the flow.
// Reset:
//   Synchronous, active high. Parser returns to sync hunt, registers take
//   their defaults, captured words and last time go to zero.
// Stall:
//   While a response waits, one more request is taken into the input
//   register; that byte is held until the response is taken, then req
//   ready drops only if the held byte cannot move.
// ----------------------------------------------------------------------------
module crc32_checked_frame_parser
   import ccfp_pkg::*;
#(
   parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   ccfp_req_if.sink             req_bus,
   ccfp_rsp_if.source           rsp_bus,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]          csr_wdata
);

   // payload counter only needs to reach MAX_PAYLOAD-1
   localparam int          CW        = $clog2(MAX_PAYLOAD);
   localparam logic [16:0] LEN_LIMIT = 17'(MAX_PAYLOAD);

   // parse phases
   localparam logic [3:0] PH_SYNC1   = 4'd0;
   localparam logic [3:0] PH_SYNC2   = 4'd1;
   localparam logic [3:0] PH_ID_LO   = 4'd2;
   localparam logic [3:0] PH_ID_HI   = 4'd3;
   localparam logic [3:0] PH_LEN_LO  = 4'd4;
   localparam logic [3:0] PH_LEN_HI  = 4'd5;
   localparam logic [3:0] PH_PAYLOAD = 4'd6;
   localparam logic [3:0] PH_CHK1    = 4'd7;
   localparam logic [3:0] PH_CHK2    = 4'd8;
   localparam logic [3:0] PH_CHK3    = 4'd9;
   localparam logic [3:0] PH_CHK4    = 4'd10;

   // config registers
   logic [7:0]  sync_first_ff,   sync_first_in;
   logic [7:0]  sync_second_ff,  sync_second_in;
   logic [15:0] nav_frame_id_ff, nav_frame_id_in;
   logic [31:0] crc_seed_ff,     crc_seed_in;

   // input register
   logic        byte_vld_ff, byte_vld_in;
   logic [7:0]  byte_ff,     byte_in;

   // parse state
   logic [3:0]    phase_ff,     phase_in;
   logic [CW-1:0] count_ff,     count_in;
   logic [15:0]   held_id_ff,   held_id_in;
   logic [15:0]   held_len_ff,  held_len_in;
   logic [31:0]   crc_ff,       crc_in;
   logic [23:0]   check_ff,     check_in;
   word_type      word_ff [NUM_WORDS];
   word_type      word_in [NUM_WORDS];
   logic [31:0]   last_time_ff, last_time_in;

   // response register
   logic        rsp_vld_ff,    rsp_vld_in;
   logic [1:0]  status_ff,     status_in;
   logic [15:0] rsp_id_ff,     rsp_id_in;
   logic [8:0]  rsp_len_ff,    rsp_len_in;
   logic [31:0] delta_ff,      delta_in;
   word_type    rsp_word_ff [NUM_WORDS-1];
   word_type    rsp_word_in [NUM_WORDS-1];

   logic        advance;
   logic        take_req;
   logic [31:0] crc_src;
   logic [31:0] crc_step;
   logic [15:0] len_new;
   logic [CW-1:0] count_nxt;
   logic [CW-1:0] rel_off;
   logic [WORD_IDX_W-1:0] cap_idx;
   logic [1:0]  cap_lane;
   logic        cap_hit;
   logic [31:0] check_word;

   // held byte moves when the response slot is free or being drained
   assign advance  = byte_vld_ff && (!rsp_vld_ff || rsp_bus.ready);
   assign req_bus.ready = !byte_vld_ff || advance;
   assign take_req = req_bus.valid && req_bus.ready;

   // CRC restarts from the seed on a first sync byte
   assign crc_src  = (phase_ff == PH_SYNC1) ? crc_seed_ff : crc_ff;
   assign crc_step = crc_byte(crc_src, byte_ff);

   assign len_new    = {byte_ff, held_len_ff[7:0]};
   assign count_nxt  = count_ff + CW'(1);
   assign check_word = {byte_ff, check_ff};

   // capture window: time of week at offsets 0..3, six words from offset 50
   always_comb begin
      rel_off  = count_ff - CW'(FIRST_WORD_OFFSET);
      cap_hit  = 1'b0;
      cap_idx  = '0;
      cap_lane = count_ff[1:0];
      if (count_ff < CW'(4)) begin
         cap_hit = 1'b1;
      end else if (count_ff >= CW'(FIRST_WORD_OFFSET) && count_ff < CW'(LAST_WORD_END)) begin
         cap_hit  = 1'b1;
         cap_idx  = rel_off[4:2] + WORD_IDX_W'(1);
         cap_lane = rel_off[1:0];
      end
   end

   // config writes
   always_comb begin
      sync_first_in   = sync_first_ff;
      sync_second_in  = sync_second_ff;
      nav_frame_id_in = nav_frame_id_ff;
      crc_seed_in     = crc_seed_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_SYNC_FIRST:   sync_first_in   = csr_wdata[7:0];
            CSR_SYNC_SECOND:  sync_second_in  = csr_wdata[7:0];
            CSR_NAV_FRAME_ID: nav_frame_id_in = csr_wdata[15:0];
            CSR_CRC_SEED:     crc_seed_in     = csr_wdata;
            default:          ;
         endcase
      end
   end

   // input register
   always_comb begin
      byte_vld_in = byte_vld_ff;
      byte_in     = byte_ff;
      if (take_req) begin
         byte_vld_in = 1'b1;
         byte_in     = req_bus.rx_byte;
      end else if (advance) begin
         byte_vld_in = 1'b0;
      end
   end

   // parse step
   always_comb begin
      phase_in     = phase_ff;
      count_in     = count_ff;
      held_id_in   = held_id_ff;
      held_len_in  = held_len_ff;
      crc_in       = crc_ff;
      check_in     = check_ff;
      last_time_in = last_time_ff;
      for (int i = 0; i < NUM_WORDS; i++) begin
         word_in[i] = word_ff[i];
      end

      rsp_vld_in = rsp_vld_ff && !rsp_bus.ready;
      status_in  = status_ff;
      rsp_id_in  = rsp_id_ff;
      rsp_len_in = rsp_len_ff;
      delta_in   = delta_ff;
      for (int i = 0; i < NUM_WORDS - 1; i++) begin
         rsp_word_in[i] = rsp_word_ff[i];
      end

      if (advance) begin
         unique case (phase_ff)
            PH_SYNC1: begin
               if (byte_ff == sync_first_ff) begin
                  crc_in   = crc_step;
                  phase_in = PH_SYNC2;
               end
            end
            PH_SYNC2: begin
               // a wrong second byte is not retried as a first sync byte
               if (byte_ff == sync_second_ff) begin
                  crc_in   = crc_step;
                  phase_in = PH_ID_LO;
               end else begin
                  phase_in = PH_SYNC1;
               end
            end
            PH_ID_LO: begin
               held_id_in = {8'd0, byte_ff};
               crc_in     = crc_step;
               phase_in   = PH_ID_HI;
            end
            PH_ID_HI: begin
               held_id_in = {byte_ff, held_id_ff[7:0]};
               crc_in     = crc_step;
               phase_in   = PH_LEN_LO;
            end
            PH_LEN_LO: begin
               held_len_in = {8'd0, byte_ff};
               crc_in      = crc_step;
               phase_in    = PH_LEN_HI;
            end
            PH_LEN_HI: begin
               held_len_in = len_new;
               crc_in      = crc_step;
               if (len_new != 16'd0 && {1'b0, len_new} < LEN_LIMIT) begin
                  count_in = '0;
                  phase_in = PH_PAYLOAD;
               end else begin
                  phase_in = PH_SYNC1;
               end
            end
            PH_PAYLOAD: begin
               if (cap_hit) begin
                  word_in[cap_idx][{cap_lane, 3'b000} +: 8] = byte_ff;
               end
               crc_in   = crc_step;
               count_in = count_nxt;
               if (17'(count_nxt) >= {1'b0, held_len_ff}) begin
                  phase_in = PH_CHK1;
               end
            end
            PH_CHK1: begin
               check_in = {16'd0, byte_ff};
               phase_in = PH_CHK2;
            end
            PH_CHK2: begin
               check_in = {8'd0, byte_ff, check_ff[7:0]};
               phase_in = PH_CHK3;
            end
            PH_CHK3: begin
               check_in = {byte_ff, check_ff[15:0]};
               phase_in = PH_CHK4;
            end
            PH_CHK4: begin
               rsp_vld_in = 1'b1;
               rsp_id_in  = held_id_ff;
               rsp_len_in = held_len_ff[8:0];
               delta_in   = '0;
               for (int i = 0; i < NUM_WORDS - 1; i++) begin
                  rsp_word_in[i] = '0;
               end
               if (check_word != crc_ff) begin
                  status_in = STATUS_CRC_BAD;
               end else if (held_id_ff != nav_frame_id_ff) begin
                  status_in = STATUS_OTHER_ID;
               end else begin
                  status_in    = STATUS_NAV_OK;
                  delta_in     = word_ff[0] - last_time_ff;
                  last_time_in = word_ff[0];
                  for (int i = 0; i < NUM_WORDS - 1; i++) begin
                     rsp_word_in[i] = word_ff[i+1];
                  end
               end
               phase_in = PH_SYNC1;
               count_in = '0;
               crc_in   = crc_seed_ff;
            end
            default: begin
               phase_in = PH_SYNC1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_first_ff   <= SYNC_FIRST_RESET;
         sync_second_ff  <= SYNC_SECOND_RESET;
         nav_frame_id_ff <= NAV_FRAME_ID_RESET;
         crc_seed_ff     <= CRC_SEED_RESET;
         byte_vld_ff     <= 1'b0;
         phase_ff        <= PH_SYNC1;
         count_ff        <= '0;
         held_id_ff      <= '0;
         held_len_ff     <= '0;
         crc_ff          <= CRC_SEED_RESET;
         check_ff        <= '0;
         last_time_ff    <= '0;
         for (int i = 0; i < NUM_WORDS; i++) begin
            word_ff[i] <= '0;
         end
         rsp_vld_ff      <= 1'b0;
      end else begin
         sync_first_ff   <= sync_first_in;
         sync_second_ff  <= sync_second_in;
         nav_frame_id_ff <= nav_frame_id_in;
         crc_seed_ff     <= crc_seed_in;
         byte_vld_ff     <= byte_vld_in;
         phase_ff        <= phase_in;
         count_ff        <= count_in;
         held_id_ff      <= held_id_in;
         held_len_ff     <= held_len_in;
         crc_ff          <= crc_in;
         check_ff        <= check_in;
         last_time_ff    <= last_time_in;
         for (int i = 0; i < NUM_WORDS; i++) begin
            word_ff[i] <= word_in[i];
         end
         rsp_vld_ff      <= rsp_vld_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      byte_ff    <= byte_in;
      status_ff  <= status_in;
      rsp_id_ff  <= rsp_id_in;
      rsp_len_ff <= rsp_len_in;
      delta_ff   <= delta_in;
      for (int i = 0; i < NUM_WORDS - 1; i++) begin
         rsp_word_ff[i] <= rsp_word_in[i];
      end
   end

   assign rsp_bus.valid         = rsp_vld_ff;
   assign rsp_bus.frame_status  = status_ff;
   assign rsp_bus.pkt_id        = rsp_id_ff;
   assign rsp_bus.frame_length  = rsp_len_ff;
   assign rsp_bus.time_delta_ms = delta_ff;
   assign rsp_bus.accel_x_bits  = rsp_word_ff[0];
   assign rsp_bus.accel_y_bits  = rsp_word_ff[1];
   assign rsp_bus.accel_z_bits  = rsp_word_ff[2];
   assign rsp_bus.gyro_x_bits   = rsp_word_ff[3];
   assign rsp_bus.gyro_y_bits   = rsp_word_ff[4];
   assign rsp_bus.gyro_z_bits   = rsp_word_ff[5];

endmodule

/* hw/rtl/ccfp_checker.sv */
// ----------------------------------------------------------------------------
// ccfp_checker
// Port-level checks for the frame parser, bound to the top level.
// ----------------------------------------------------------------------------
module ccfp_checker
   import ccfp_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  frame_status,
   input logic [15:0] pkt_id,
   input logic [31:0] time_delta_ms,
   input logic [31:0] accel_x_bits,
   input logic [31:0] gyro_z_bits
);

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(frame_status) && $stable(pkt_id))
      else $error("response changed while stalled");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (frame_status == STATUS_NAV_OK || frame_status == STATUS_OTHER_ID ||
                     frame_status == STATUS_CRC_BAD))
      else $error("undefined frame status");

   // only a good nav frame carries decoded fields
   a_zero_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && frame_status != STATUS_NAV_OK |->
         time_delta_ms == 32'd0 && accel_x_bits == 32'd0 && gyro_z_bits == 32'd0)
      else $error("decoded fields set on non-nav response");

   // a draining response never blocks requests
   a_no_bubble: assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("request stalled while response side ready");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind crc32_checked_frame_parser ccfp_checker u_ccfp_checker (
   .clock         (clock),
   .reset         (reset),
   .req_ready     (req_bus.ready),
   .rsp_valid     (rsp_bus.valid),
   .rsp_ready     (rsp_bus.ready),
   .frame_status  (rsp_bus.frame_status),
   .pkt_id        (rsp_bus.pkt_id),
   .time_delta_ms (rsp_bus.time_delta_ms),
   .accel_x_bits  (rsp_bus.accel_x_bits),
   .gyro_z_bits   (rsp_bus.gyro_z_bits)
);

/* dv/ccfp_frame_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccfp_frame_checker
// Watches the request, response and register ports of the frame parser. It
// keeps its own copy of the parser state and registers, works out the
// verdict of each finished frame and checks every response against it.
// ----------------------------------------------------------------------------
module ccfp_frame_checker
   import ccfp_pkg::*;
#(
   parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   ccfp_req_if                  req_bus,
   ccfp_rsp_if                  rsp_bus,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]          csr_wdata,
   output int                   error_count,
   output int                   frames_pending
);

   typedef enum logic [3:0] {
      HUNT_FIRST, HUNT_SECOND, ID_LOW, ID_HIGH, LEN_LOW, LEN_HIGH,
      PAYLOAD_BYTES, CHECK_B0, CHECK_B1, CHECK_B2, CHECK_B3
   } parse_step_type;

   typedef struct packed {
      logic [1:0]       status;
      logic [15:0]      id;
      logic [8:0]       length;
      logic [31:0]      tow_delta;
      logic [5:0][31:0] imu;       // accel x,y,z then gyro x,y,z
   } verdict_type;

   // register copies
   logic [7:0]  cfg_sync_first;
   logic [7:0]  cfg_sync_second;
   logic [15:0] cfg_nav_id;
   logic [31:0] cfg_seed;

   // parser copy
   parse_step_type step;
   int unsigned payload_taken;
   logic [15:0] hdr_id;
   logic [15:0] hdr_len;
   logic [31:0] crc_run;
   logic [23:0] check_low;
   word_type    nav_word [NUM_WORDS];
   logic [31:0] prev_tow;

   verdict_type verdict_q [$];
   verdict_type want;
   logic [5:0][31:0] got_imu;
   string       imu_field [6] = '{"accel_x_bits", "accel_y_bits", "accel_z_bits",
                                  "gyro_x_bits", "gyro_y_bits", "gyro_z_bits"};

   initial error_count = 0;
   initial frames_pending = 0;

   function automatic logic [31:0] crc32_step(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      repeat (8) c = {1'b0, c[31:1]} ^ (c[0] ? CRC_POLY : 32'd0);
      return c;
   endfunction

   task automatic report_failure(input string msg);
      $display("%0t ERROR: %s", $time, msg);
      error_count++;
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] exp_val);
      if (got !== exp_val) begin
         report_failure($sformatf("%s got %h, want %h", name, got, exp_val));
      end
   endtask

   // one stream byte through the parser copy; a finished frame queues a verdict
   task automatic parse_byte(input logic [7:0] b);
      logic [31:0] check_word;
      verdict_type v;
      int unsigned rel;
      case (step)
         HUNT_FIRST: begin
            if (b == cfg_sync_first) begin
               crc_run = crc32_step(cfg_seed, b);
               step = HUNT_SECOND;
            end
         end
         HUNT_SECOND: begin
            if (b == cfg_sync_second) begin
               crc_run = crc32_step(crc_run, b);
               step = ID_LOW;
            end else begin
               step = HUNT_FIRST;
            end
         end
         ID_LOW: begin
            hdr_id = {8'd0, b};
            crc_run = crc32_step(crc_run, b);
            step = ID_HIGH;
         end
         ID_HIGH: begin
            hdr_id[15:8] = b;
            crc_run = crc32_step(crc_run, b);
            step = LEN_LOW;
         end
         LEN_LOW: begin
            hdr_len = {8'd0, b};
            crc_run = crc32_step(crc_run, b);
            step = LEN_HIGH;
         end
         LEN_HIGH: begin
            hdr_len[15:8] = b;
            crc_run = crc32_step(crc_run, b);
            if (hdr_len != 16'd0 && hdr_len < MAX_PAYLOAD) begin
               payload_taken = 0;
               step = PAYLOAD_BYTES;
            end else begin
               step = HUNT_FIRST;
            end
         end
         PAYLOAD_BYTES: begin
            if (payload_taken < 4) begin
               nav_word[0][8*payload_taken +: 8] = b;
            end else if (payload_taken >= FIRST_WORD_OFFSET &&
                         payload_taken < LAST_WORD_END) begin
               rel = payload_taken - FIRST_WORD_OFFSET;
               nav_word[1 + rel / 4][8*(rel % 4) +: 8] = b;
            end
            crc_run = crc32_step(crc_run, b);
            payload_taken++;
            if (payload_taken >= hdr_len) step = CHECK_B0;
         end
         CHECK_B0: begin
            check_low = {16'd0, b};
            step = CHECK_B1;
         end
         CHECK_B1: begin
            check_low[15:8] = b;
            step = CHECK_B2;
         end
         CHECK_B2: begin
            check_low[23:16] = b;
            step = CHECK_B3;
         end
         CHECK_B3: begin
            check_word = {b, check_low};
            v = '0;
            v.id = hdr_id;
            v.length = hdr_len[8:0];
            if (check_word != crc_run) begin
               v.status = STATUS_CRC_BAD;
            end else if (hdr_id != cfg_nav_id) begin
               v.status = STATUS_OTHER_ID;
            end else begin
               v.status = STATUS_NAV_OK;
               v.tow_delta = nav_word[0] - prev_tow;
               prev_tow = nav_word[0];
               for (int k = 0; k < 6; k++) v.imu[k] = nav_word[k + 1];
            end
            verdict_q.insert(verdict_q.size(), v);
            step = HUNT_FIRST;
            payload_taken = 0;
            crc_run = cfg_seed;
         end
         default: step = HUNT_FIRST;
      endcase
   endtask

   always @(posedge clock) begin
      if (reset) begin
         cfg_sync_first = SYNC_FIRST_RESET;
         cfg_sync_second = SYNC_SECOND_RESET;
         cfg_nav_id = NAV_FRAME_ID_RESET;
         cfg_seed = CRC_SEED_RESET;
         step = HUNT_FIRST;
         payload_taken = 0;
         hdr_id = '0;
         hdr_len = '0;
         crc_run = CRC_SEED_RESET;
         check_low = '0;
         foreach (nav_word[k]) nav_word[k] = '0;
         prev_tow = '0;
         verdict_q.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_SYNC_FIRST:   cfg_sync_first = csr_wdata[7:0];
               CSR_SYNC_SECOND:  cfg_sync_second = csr_wdata[7:0];
               CSR_NAV_FRAME_ID: cfg_nav_id = csr_wdata[15:0];
               CSR_CRC_SEED:     cfg_seed = csr_wdata;
               default: ;
            endcase
         end
         if (req_bus.valid && req_bus.ready) parse_byte(req_bus.rx_byte);
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (verdict_q.size() == 0) begin
               report_failure($sformatf("response with none pending, id %h status %0d",
                                        rsp_bus.pkt_id, rsp_bus.frame_status));
            end else begin
               want = verdict_q.pop_front();
               got_imu = {rsp_bus.gyro_z_bits, rsp_bus.gyro_y_bits, rsp_bus.gyro_x_bits,
                          rsp_bus.accel_z_bits, rsp_bus.accel_y_bits, rsp_bus.accel_x_bits};
               check_field("frame_status", 32'(rsp_bus.frame_status), 32'(want.status));
               check_field("pkt_id", 32'(rsp_bus.pkt_id), 32'(want.id));
               check_field("frame_length", 32'(rsp_bus.frame_length), 32'(want.length));
               check_field("time_delta_ms", rsp_bus.time_delta_ms, want.tow_delta);
               for (int k = 0; k < 6; k++) check_field(imu_field[k], got_imu[k], want.imu[k]);
            end
         end
      end
      frames_pending = verdict_q.size();
   end

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Feeds the frame parser byte streams built from whole frames (good nav
// frames, other ids, bad CRCs) mixed with bad headers, broken sync pairs
// and noise, over several register settings. The checker beside the parser
// predicts and compares; this module makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module testbench
   import ccfp_pkg::*;
();

   localparam int CYCLE_LIMIT     = 200000;
   localparam int SETTLE_CYCLES   = 8;     // response trails its request through the input and response registers
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int PHASE_REQUESTS  = 220;
   localparam int PHASE_FRAMES    = 3;
   localparam int NUM_PHASES      = 5;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_SYNC_FIRST;
   logic [31:0]          csr_wdata = '0;
   int                   error_count;
   int                   frames_pending;

   ccfp_req_if req_bus ();
   ccfp_rsp_if rsp_bus ();

   // what the registers hold right now, used to build frames that sync
   logic [7:0]  sync_first_q  = SYNC_FIRST_RESET;
   logic [7:0]  sync_second_q = SYNC_SECOND_RESET;
   logic [15:0] nav_id_q      = NAV_FRAME_ID_RESET;
   logic [31:0] seed_q        = CRC_SEED_RESET;

   logic [7:0]  stream_q [$];      // bytes waiting to go out as requests
   logic [31:0] tow_ms = '0;       // running time of week put into payloads
   int          requests_sent = 0;
   int          frames_queued = 0;
   bit          hold_responses = 1'b0;
   bit          sender_eager = 1'b0;
   int          cycle_count;

   always #1 clock = ~clock;

   crc32_checked_frame_parser dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   ccfp_frame_checker verdict_check (
      .clock          (clock),
      .reset          (reset),
      .req_bus        (req_bus),
      .rsp_bus        (rsp_bus),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .error_count    (error_count),
      .frames_pending (frames_pending)
   );

   // --------------------------------------------------------------------------
   // frame building
   // --------------------------------------------------------------------------

   // append one byte to the outgoing stream
   function automatic void stream_put(input logic [7:0] b);
      stream_q.insert(stream_q.size(), b);
   endfunction

   // sync pair, header, payload, then the CRC as little-endian check word;
   // payload bytes 0..3 carry the time of week, the rest is random
   function automatic void queue_frame(input logic [15:0] id, input logic [15:0] len,
                                       input bit bad_crc);
      logic [7:0]  body [$];
      logic [31:0] crc;
      body = '{sync_first_q, sync_second_q, id[7:0], id[15:8], len[7:0], len[15:8]};
      // mostly small steps, now and then a jump that may wrap
      if ($urandom_range(0, 9) == 0) tow_ms = $urandom();
      else tow_ms += $urandom_range(0, 1000);
      for (int k = 0; k < len; k++) begin
         if (k < 4) body.insert(body.size(), tow_ms[8*k +: 8]);
         else body.insert(body.size(), 8'($urandom_range(0, 255)));
      end
      crc = seed_q;
      foreach (body[k]) crc = crc_byte(crc, body[k]);
      if (bad_crc) crc ^= 32'd1 << $urandom_range(0, 31);
      for (int k = 0; k < 4; k++) body.insert(body.size(), crc[8*k +: 8]);
      foreach (body[k]) stream_put(body[k]);
      frames_queued++;
   endfunction

   // header whose length sends the parser back to hunting
   function automatic void queue_bad_header(input logic [15:0] id, input logic [15:0] len);
      stream_put(sync_first_q);
      stream_put(sync_second_q);
      stream_put(id[7:0]);
      stream_put(id[15:8]);
      stream_put(len[7:0]);
      stream_put(len[15:8]);
   endfunction

   function automatic logic [15:0] other_id();
      logic [15:0] id;
      id = 16'($urandom_range(0, 65535));
      if (id == nav_id_q) id ^= 16'h8000;
      return id;
   endfunction

   // mostly short frames and full nav records, a few long ones
   function automatic logic [15:0] pick_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 3) return 16'($urandom_range(400, 511));
      if (r < 28) return 16'($urandom_range(1, 12));
      if (r < 43) return 16'($urandom_range(13, 73));
      return 16'($urandom_range(74, 90));
   endfunction

   // --------------------------------------------------------------------------
   // request side
   // --------------------------------------------------------------------------

   // drain stream_q in bursts; valid stays high across a burst and across
   // back-to-back bursts when there is no gap
   task automatic send_stream();
      int burst;
      int gap;
      while (stream_q.size() != 0) begin
         burst = $urandom_range(1, 24);
         gap = sender_eager ? 0 : $urandom_range(0, 6);
         while (burst > 0 && stream_q.size() != 0) begin
            req_bus.valid <= 1'b1;
            req_bus.rx_byte <= stream_q.pop_front();
            @(posedge clock);
            while (!req_bus.ready) @(posedge clock);
            requests_sent++;
            burst--;
            @(negedge clock);
         end
         if (gap != 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
   endtask

   // no request offered, every verdict back, pipeline drained
   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      while (frames_pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic csr_put(input logic [CSR_IDX_W-1:0] index, input logic [31:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(negedge clock);
   endtask

   task automatic program_registers(input logic [7:0] s1, input logic [7:0] s2,
                                    input logic [15:0] nav, input logic [31:0] seed);
      wait_idle();
      csr_put(CSR_SYNC_FIRST, {24'd0, s1});
      csr_put(CSR_SYNC_SECOND, {24'd0, s2});
      csr_put(CSR_NAV_FRAME_ID, {16'd0, nav});
      csr_put(CSR_CRC_SEED, seed);
      csr_wr_en <= 1'b0;
      sync_first_q = s1;
      sync_second_q = s2;
      nav_id_q = nav;
      seed_q = seed;
   endtask

   // random mix under the current registers
   task automatic run_phase();
      int start_req;
      int start_frames;
      int r;
      logic [7:0] b;
      start_req = requests_sent;
      start_frames = frames_queued;
      while (requests_sent - start_req < PHASE_REQUESTS ||
             frames_queued - start_frames < PHASE_FRAMES) begin
         sender_eager = ($urandom_range(0, 5) == 0);
         r = $urandom_range(0, 99);
         if (r < 45) begin
            queue_frame(nav_id_q, pick_length(), 1'b0);
         end else if (r < 65) begin
            queue_frame(other_id(), pick_length(), 1'b0);
         end else if (r < 80) begin
            queue_frame(r[0] ? nav_id_q : other_id(), pick_length(), 1'b1);
         end else if (r < 88) begin
            case ($urandom_range(0, 3))
               0: queue_bad_header(other_id(), 16'd0);
               1: queue_bad_header(nav_id_q, 16'(MAX_PAYLOAD_DEFAULT));
               2: queue_bad_header(other_id(), 16'hFFFF);
               default: queue_bad_header(nav_id_q,
                                         16'($urandom_range(MAX_PAYLOAD_DEFAULT, 65535)));
            endcase
         end else if (r < 94) begin
            // sync pair broken on the second byte
            b = 8'($urandom_range(0, 255));
            if (b == sync_second_q) b = ~b;
            stream_put(sync_first_q);
            stream_put(b);
         end else begin
            repeat ($urandom_range(1, 4)) stream_put(8'($urandom_range(0, 255)));
         end
         send_stream();
      end
   endtask

   // --------------------------------------------------------------------------
   // response side: ready pattern in stretches of always ready, coin flip and
   // mostly stalled; a long hold-off on request from the stimulus
   // --------------------------------------------------------------------------
   initial begin : response_sink
      int mode;
      int left;
      rsp_bus.ready = 1'b0;
      mode = 0;
      left = 0;
      forever begin
         @(negedge clock);
         if (hold_responses) begin
            rsp_bus.ready <= 1'b0;
            for (int n = 0; n < HOLD_OFF_CYCLES; n++) @(negedge clock);
            hold_responses = 1'b0;
         end else begin
            if (left == 0) begin
               mode = $urandom_range(0, 2);
               left = $urandom_range(8, 80);
            end
            left--;
            case (mode)
               0: rsp_bus.ready <= 1'b1;
               1: rsp_bus.ready <= 1'($urandom_range(0, 1));
               default: rsp_bus.ready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   // --------------------------------------------------------------------------
   // run limit
   // --------------------------------------------------------------------------
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("testbench NOT OK");
      $finish;
   end

   // --------------------------------------------------------------------------
   // stimulus
   // --------------------------------------------------------------------------
   initial begin
      req_bus.valid = 1'b0;
      req_bus.rx_byte = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed, reset registers
      // first sync byte twice: the second one breaks the pair and is not
      // taken as a new start
      stream_put(sync_first_q);
      stream_put(sync_first_q);
      // zero length and length at the payload limit both drop the header
      queue_bad_header(16'hFFFF, 16'd0);
      queue_bad_header(16'h0000, 16'(MAX_PAYLOAD_DEFAULT));
      queue_frame(16'h0000, 16'd1, 1'b0);           // good CRC, other id
      queue_frame(nav_id_q, 16'd2, 1'b1);           // nav id, CRC mismatch
      queue_frame(nav_id_q, 16'd4, 1'b0);           // short nav: only time taken
      send_stream();

      // backlog: receiver holds off while short frames keep coming, so the
      // parser fills up and has to stall its request side
      hold_responses = 1'b1;
      sender_eager = 1'b1;
      repeat (8) queue_frame($urandom_range(0, 1) ? nav_id_q : other_id(),
                             16'($urandom_range(1, 6)), 1'b0);
      send_stream();

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         case (phase)
            0: program_registers(SYNC_FIRST_RESET, SYNC_SECOND_RESET,
                                 NAV_FRAME_ID_RESET, CRC_SEED_RESET);
            1: program_registers(8'h00, 8'hFF, 16'h0000, 32'h0000_0000);
            2: program_registers(8'hFF, 8'h00, 16'hFFFF, 32'hFFFF_FFFF);
            3: begin
               // equal sync bytes
               program_registers(8'h3C, 8'h3C, 16'($urandom_range(0, 65535)), $urandom());
            end
            default: program_registers(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                       16'($urandom_range(0, 65535)), $urandom());
         endcase
         if (phase == 2) begin
            // longest payload the parser accepts
            queue_frame(nav_id_q, 16'd511, 1'b0);
            send_stream();
         end
         run_phase();
      end

      wait_idle();
      if (error_count == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

endmodule
